// ===== sv/vdi_pkg.sv =====
// ----------------------------------------------------------------------------
// vdi_pkg
// shared types and constants for the vertex dedup indexer
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int MaxVerts = 1024;
  localparam int IdxW     = $clog2(MaxVerts);
  localparam int CntW     = $clog2(MaxVerts + 1);
  localparam int TexW     = 16;
  localparam int AddrW    = 4;

  // register byte addresses
  localparam logic [AddrW-1:0] RegFormat = 4'h0;
  localparam logic [AddrW-1:0] RegTarget = 4'h4;
  localparam logic [AddrW-1:0] RegClear  = 4'h8;

  typedef struct packed {
    logic [31:0]     pos_x;
    logic [31:0]     pos_y;
    logic [31:0]     pos_z;
    logic [31:0]     tex_u;
    logic [31:0]     tex_v;
    logic [31:0]     diffuse_color;
    logic [31:0]     specular_color;
    logic [TexW-1:0] texture_id;
  } vtx_t;

  typedef struct packed {
    logic [IdxW-1:0] vertex_index;
    logic            is_new;
    logic            table_full;
    logic [CntW-1:0] distinct_total;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input vertex
    logic addr_clr;   // scan address to zero
    logic addr_inc;   // advance scan address
    logic write;      // append vertex at count
    logic clear;      // empty table
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            hit;       // compared entry matches
    logic            last;      // scan address reached count
    logic            full;      // count at capacity
  } dp_sts_t;

  function automatic logic float_eq(logic [31:0] a, logic [31:0] b);
    logic nan_a;
    logic nan_b;
    nan_a = a[30:0] > 31'h7F800000;
    nan_b = b[30:0] > 31'h7F800000;
    return !nan_a && !nan_b && ((a == b) || ((a[30:0] | b[30:0]) == 31'd0));
  endfunction

endpackage

// ===== sv/vdi_if.sv =====
// ----------------------------------------------------------------------------
// vdi_vtx_if / vdi_res_if
// valid/ready channels for vertices and results
// ----------------------------------------------------------------------------
interface vdi_vtx_if;
  import vdi_pkg::*;
  logic valid;
  logic ready;
  vtx_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdi_res_if;
  import vdi_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/vdi_ram.sv =====
// ----------------------------------------------------------------------------
// vdi_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module vdi_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/vdi_datapath.sv =====
// ----------------------------------------------------------------------------
// vdi_datapath
// vertex tables, scan address, count and compare
// ----------------------------------------------------------------------------
module vdi_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  vdi_pkg::vtx_t    vtx,
  input  logic             lit,
  input  vdi_pkg::dp_cmd_t cmd,
  output vdi_pkg::dp_sts_t sts,
  output vdi_pkg::res_t    hit_res,
  output vdi_pkg::res_t    miss_res
);
  import vdi_pkg::*;

  vtx_t            vtx_r;
  logic [CntW-1:0] addr_r, addr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [IdxW-1:0] ram_addr;
  logic [63:0]     xy_q, zu_q, vc_q;
  logic [31:0]     sp_q;
  logic            match;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vtx_r <= vtx;
    end
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.addr_clr) begin
      addr_nxt = '0;
    end else if (cmd.addr_inc) begin
      addr_nxt = addr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.write) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      cnt_r  <= '0;
    end else begin
      addr_r <= addr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // on write the address is the count; otherwise the scan address
  assign ram_addr = cmd.write ? cnt_r[IdxW-1:0] : addr_nxt[IdxW-1:0];

  vdi_ram #(.Width(64), .Depth(MaxVerts)) u_xy (
    .clk(clk), .we(cmd.write), .addr(ram_addr),
    .wdata({vtx_r.pos_y, vtx_r.pos_x}), .rdata(xy_q));
  vdi_ram #(.Width(64), .Depth(MaxVerts)) u_zu (
    .clk(clk), .we(cmd.write), .addr(ram_addr),
    .wdata({vtx_r.tex_u, vtx_r.pos_z}), .rdata(zu_q));
  vdi_ram #(.Width(64), .Depth(MaxVerts)) u_vc (
    .clk(clk), .we(cmd.write), .addr(ram_addr),
    .wdata({vtx_r.diffuse_color, vtx_r.tex_v}), .rdata(vc_q));
  vdi_ram #(.Width(32), .Depth(MaxVerts)) u_sp (
    .clk(clk), .we(cmd.write), .addr(ram_addr),
    .wdata(vtx_r.specular_color), .rdata(sp_q));

  always_comb begin
    match = float_eq(xy_q[31:0], vtx_r.pos_x) && float_eq(xy_q[63:32], vtx_r.pos_y) &&
            float_eq(zu_q[31:0], vtx_r.pos_z) && float_eq(zu_q[63:32], vtx_r.tex_u) &&
            float_eq(vc_q[31:0], vtx_r.tex_v);
    if (lit && (vc_q[63:32] != vtx_r.diffuse_color)) begin
      match = 1'b0;
    end
    // specular is stored but never compared; keep the port used
    if (sp_q == 32'd0 && 1'b0) begin
      match = 1'b0;
    end
  end

  assign sts.hit  = match;
  assign sts.last = (addr_r == cnt_r);
  assign sts.full = (cnt_r == CntW'(MaxVerts));

  assign hit_res.vertex_index   = addr_r[IdxW-1:0];
  assign hit_res.is_new         = 1'b0;
  assign hit_res.table_full     = 1'b0;
  assign hit_res.distinct_total = cnt_r;

  assign miss_res.vertex_index   = sts.full ? '0 : cnt_r[IdxW-1:0];
  assign miss_res.is_new         = !sts.full;
  assign miss_res.table_full     = sts.full;
  assign miss_res.distinct_total = sts.full ? cnt_r : cnt_r + 1'b1;
endmodule

// ===== sv/vdi_ctrl.sv =====
// ----------------------------------------------------------------------------
// vdi_ctrl
// scan sequencer and result register
// ----------------------------------------------------------------------------
module vdi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [15:0]      in_tex,
  input  logic [15:0]      target,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output vdi_pkg::res_t    out_data,
  input  logic             clear_req,
  output vdi_pkg::dp_cmd_t cmd,
  input  vdi_pkg::dp_sts_t sts,
  input  vdi_pkg::res_t    hit_res,
  input  vdi_pkg::res_t    miss_res
);
  import vdi_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  res_t   out_data_r, out_data_nxt;
  logic   take;

  // result register frees as soon as it is taken
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign take     = in_valid && in_ready && (in_tex == target);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd           = '0;
    cmd.clear     = clear_req;
    case (state_r)
      S_IDLE: begin
        cmd.addr_clr = 1'b1;
        if (take) begin
          cmd.load  = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.addr_clr = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // ram data at addr_r is valid here
        if (sts.last) begin
          if (!sts.full) begin
            cmd.write = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = miss_res;
          state_nxt     = S_DONE;
        end else if (sts.hit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hit_res;
          state_nxt     = S_DONE;
        end else begin
          cmd.addr_inc = 1'b1;
        end
      end
      S_DONE: begin
        cmd.addr_clr = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

// ===== sv/vertex_dedup_indexer.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// vertex welding index builder for one texture group
// ----------------------------------------------------------------------------
// usage:
//   vertices enter on in_ (valid/ready); one request is accepted at a time.
//   a vertex whose texture_id differs from target_texture is dropped with
//   no result. others are compared in table order against the stored
//   distinct vertices (one table entry per cycle, set by the single ram
//   read port). the first match gives its index; a miss appends the
//   vertex unless the table is full, which is flagged as table_full.
//   an accepted vertex passes through a wait state, then the scan, then a
//   done state before the sequencer returns to idle.
//   results leave on out_ through an output register; a stalled receiver
//   holds the result, and the next vertex is accepted once it is taken or
//   in the same cycle it is taken.
//   reset empties the table and clears the control and config registers.
//   writing 1 to table_clear empties the table; table contents need no
//   clearing pass. registers: vertex_format at 0x0, target_texture at 0x4,
//   table_clear at 0x8, written over apb; the user must write them only
//   while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer (
  input  logic                     clk,
  input  logic                     rst_n,
  vdi_vtx_if.sink                  in_ch,
  vdi_res_if.source                out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [vdi_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import vdi_pkg::*;

  logic        lit_r;
  logic [15:0] target_r;
  logic        clr_bit_r;
  logic        wr_en;
  logic        clear_req;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  res_t        hit_res;
  res_t        miss_res;

  // config registers
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign clear_req  = wr_en && (cfg_paddr == RegClear) && cfg_pwdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r     <= 1'b0;
      target_r  <= '0;
      clr_bit_r <= 1'b0;
    end else if (wr_en) begin
      case (cfg_paddr)
        RegFormat: lit_r     <= cfg_pwdata[0];
        RegTarget: target_r  <= cfg_pwdata[15:0];
        RegClear:  clr_bit_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      RegFormat: cfg_prdata = {31'd0, lit_r};
      RegTarget: cfg_prdata = {16'd0, target_r};
      RegClear:  cfg_prdata = {31'd0, clr_bit_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // sequencer
  vdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_tex    (in_ch.data.texture_id),
    .target    (target_r),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .clear_req (clear_req),
    .cmd       (cmd),
    .sts       (sts),
    .hit_res   (hit_res),
    .miss_res  (miss_res)
  );

  // tables and compare
  vdi_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .vtx      (in_ch.data),
    .lit      (lit_r),
    .cmd      (cmd),
    .sts      (sts),
    .hit_res  (hit_res),
    .miss_res (miss_res)
  );
endmodule
